### design/plf_pkg.sv
// Shared types, codes and constants of the packet length filter.
package plf_pkg;

  // Lag queue sizing, copy cap, window defaults and register bus widths
  localparam int LAG_DEPTH_DEF   = 2048;
  localparam int KEEP_LIMIT      = 2000;
  localparam int MAX_COPIES      = 50;
  localparam logic [15:0] DEFAULT_MIN_LEN = 16'd64;
  localparam logic [15:0] DEFAULT_MAX_LEN = 16'd1500;
  localparam int CFG_ADDR_W      = 5;
  localparam int CFG_DATA_W      = 32;

  // Register indexes (byte address is four times the index)
  localparam logic [2:0] REG_DIR_EN    = 3'd0;
  localparam logic [2:0] REG_MIN_LEN   = 3'd1;
  localparam logic [2:0] REG_MAX_LEN   = 3'd2;
  localparam logic [2:0] REG_M_ACTION  = 3'd3;
  localparam logic [2:0] REG_U_ACTION  = 3'd4;
  localparam logic [2:0] REG_LAG_MS    = 3'd5;
  localparam logic [2:0] REG_M_COPIES  = 3'd6;
  localparam logic [2:0] REG_U_COPIES  = 3'd7;

  // Action codes
  typedef enum logic [2:0] {
    ACT_PASS  = 3'd0,
    ACT_DROP  = 3'd1,
    ACT_LAG   = 3'd2,
    ACT_DUP   = 3'd3,
    ACT_RESET = 3'd4,
    ACT_OOO   = 3'd5
  } action_t;

  // Operation codes of an input transaction
  typedef enum logic [1:0] {
    OP_PACKET = 2'd0,
    OP_POLL   = 2'd1,
    OP_FLUSH  = 2'd2
  } op_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] now_ms;
    logic [15:0] packet_handle;
    logic [15:0] packet_length;
    logic        is_outbound;
  } in_item_t;

  typedef struct packed {
    logic [15:0] out_handle;
    logic [15:0] out_length;
    logic        out_outbound;
    logic        is_copy;
    logic        from_lag;
    logic        last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  direction_enable;
    logic [15:0] min_length;
    logic [15:0] max_length;
    logic [2:0]  hit_action;
    logic [2:0]  miss_action;
    logic [13:0] lag_ms;
    logic [5:0]  matched_copies;
    logic [5:0]  unmatched_copies;
  } cfg_t;

endpackage

### design/plf_regs.sv
// APB-style configuration register bank of the packet length filter.
module plf_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [plf_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [plf_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [plf_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready,
  output plf_pkg::cfg_t                   cfg
);

  plf_pkg::cfg_t cfg_r;
  logic [2:0]    reg_idx;
  logic          wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;
  assign cfg     = cfg_r;

  // Write registers on the access phase of a write transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.direction_enable <= 2'd3;
      cfg_r.min_length       <= plf_pkg::DEFAULT_MIN_LEN;
      cfg_r.max_length       <= plf_pkg::DEFAULT_MAX_LEN;
      cfg_r.hit_action       <= plf_pkg::ACT_DROP;
      cfg_r.miss_action      <= plf_pkg::ACT_PASS;
      cfg_r.lag_ms           <= 14'd50;
      cfg_r.matched_copies   <= 6'd2;
      cfg_r.unmatched_copies <= 6'd2;
    end else if (wr_en) begin
      unique case (reg_idx)
        plf_pkg::REG_DIR_EN:   cfg_r.direction_enable <= pwdata[1:0];
        plf_pkg::REG_MIN_LEN:  cfg_r.min_length       <= pwdata[15:0];
        plf_pkg::REG_MAX_LEN:  cfg_r.max_length       <= pwdata[15:0];
        plf_pkg::REG_M_ACTION: cfg_r.hit_action       <= pwdata[2:0];
        plf_pkg::REG_U_ACTION: cfg_r.miss_action      <= pwdata[2:0];
        plf_pkg::REG_LAG_MS:   cfg_r.lag_ms           <= pwdata[13:0];
        plf_pkg::REG_M_COPIES: cfg_r.matched_copies   <= pwdata[5:0];
        plf_pkg::REG_U_COPIES: cfg_r.unmatched_copies <= pwdata[5:0];
      endcase
    end
  end

  // Return the addressed register, zero-extended
  always_comb begin
    unique case (reg_idx)
      plf_pkg::REG_DIR_EN:   prdata = {30'd0, cfg_r.direction_enable};
      plf_pkg::REG_MIN_LEN:  prdata = {16'd0, cfg_r.min_length};
      plf_pkg::REG_MAX_LEN:  prdata = {16'd0, cfg_r.max_length};
      plf_pkg::REG_M_ACTION: prdata = {29'd0, cfg_r.hit_action};
      plf_pkg::REG_U_ACTION: prdata = {29'd0, cfg_r.miss_action};
      plf_pkg::REG_LAG_MS:   prdata = {18'd0, cfg_r.lag_ms};
      plf_pkg::REG_M_COPIES: prdata = {26'd0, cfg_r.matched_copies};
      plf_pkg::REG_U_COPIES: prdata = {26'd0, cfg_r.unmatched_copies};
    endcase
  end

endmodule

### design/packet_length_filter_impairment.sv
// Top level of the packet length filter with lag, duplicate and drop impairments.
// A packet transaction passes, drops or enters the lag queue; a duplicate run of N
// packets holds the input while its copies are issued, one copy per output
// transaction, set by the copy sequencer behind the single output register; a poll
// or flush that finds the lag queue occupied (for a poll, also with a lag action
// selected) first reads the oldest entry from the lag memory (registered read) and
// then tests it and releases it if due (a flush is always due).
// The lag queue is one synchronous memory of LAG_DEPTH entries holding timestamp and
// descriptor, filled up to the lesser of 2000 and LAG_DEPTH entries; it needs no
// clearing pass after reset. Input stalls while a result waits in the output register
// and is stalled.
module packet_length_filter_impairment #(
  parameter int LAG_DEPTH = plf_pkg::LAG_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  plf_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output plf_pkg::out_item_t              out_data,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [plf_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [plf_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [plf_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);

  localparam int PTR_W = (LAG_DEPTH > 1) ? $clog2(LAG_DEPTH) : 1;
  localparam int CAP   = (plf_pkg::KEEP_LIMIT < LAG_DEPTH) ? plf_pkg::KEEP_LIMIT : LAG_DEPTH;
  localparam int CNT_W = $clog2(CAP + 1);
  localparam int ENT_W = 32 + 33;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_DUP
  } state_t;

  plf_pkg::cfg_t      cfg;
  state_t             state_r, state_nxt;
  logic               out_valid_r, out_valid_nxt;
  plf_pkg::out_item_t out_data_r, out_data_nxt;
  plf_pkg::in_item_t  item_r;
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   lag_count_r, lag_count_nxt;
  logic [5:0]         dup_left_r, dup_left_nxt;

  logic [ENT_W-1:0]   lag_mem_r [LAG_DEPTH];
  logic [ENT_W-1:0]   lag_rd_r;
  logic               lag_we;
  logic               lag_re;

  logic               in_acc;
  logic               out_free;
  logic               dir_on;
  logic               matched;
  logic [2:0]         act;
  logic [5:0]         copies;
  logic [5:0]         total;
  logic [31:0]        age;
  logic               due;

  plf_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  function automatic plf_pkg::out_item_t mk_out(input logic [15:0] h, input logic [15:0] l,
                                                input logic ob, input logic cp,
                                                input logic lg, input logic last);
    plf_pkg::out_item_t o;
    o.out_handle   = h;
    o.out_length   = l;
    o.out_outbound = ob;
    o.is_copy      = cp;
    o.from_lag     = lg;
    o.last_of_run  = last;
    return o;
  endfunction

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(LAG_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE) || !out_free;
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Classify the arriving packet
  assign dir_on  = in_data.is_outbound ? cfg.direction_enable[1] : cfg.direction_enable[0];
  assign matched = (in_data.packet_length >= cfg.min_length) &&
                   (in_data.packet_length <= cfg.max_length);
  assign act     = matched ? cfg.hit_action : cfg.miss_action;
  assign copies  = matched ? cfg.matched_copies : cfg.unmatched_copies;
  assign total   = (copies < 6'd2) ? 6'd1 :
                   (copies > 6'(plf_pkg::MAX_COPIES)) ? 6'(plf_pkg::MAX_COPIES) : copies;

  // Due test on the oldest lag entry
  assign age = item_r.now_ms - lag_rd_r[64:33];
  assign due = (item_r.operation == plf_pkg::OP_FLUSH) || (age > {18'd0, cfg.lag_ms});

  // Sequence transactions through the lag memory and the copy counter
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    wr_ptr_nxt    = wr_ptr_r;
    rd_ptr_nxt    = rd_ptr_r;
    lag_count_nxt = lag_count_r;
    dup_left_nxt  = dup_left_r;
    lag_we        = 1'b0;
    lag_re        = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_data.operation)
            plf_pkg::OP_PACKET: begin
              if (!dir_on) begin
                out_valid_nxt = 1'b1;
                out_data_nxt  = mk_out(in_data.packet_handle, in_data.packet_length,
                                       in_data.is_outbound, 1'b0, 1'b0, 1'b1);
              end else begin
                unique case (act)
                  plf_pkg::ACT_DROP, plf_pkg::ACT_RESET: begin
                  end
                  plf_pkg::ACT_LAG: begin
                    if (lag_count_r < CNT_W'(CAP)) begin
                      lag_we        = 1'b1;
                      wr_ptr_nxt    = next_ptr(wr_ptr_r);
                      lag_count_nxt = lag_count_r + 1'b1;
                    end else begin
                      out_valid_nxt = 1'b1;
                      out_data_nxt  = mk_out(in_data.packet_handle, in_data.packet_length,
                                             in_data.is_outbound, 1'b0, 1'b0, 1'b1);
                    end
                  end
                  plf_pkg::ACT_DUP: begin
                    out_valid_nxt = 1'b1;
                    if (total == 6'd1) begin
                      out_data_nxt = mk_out(in_data.packet_handle, in_data.packet_length,
                                            in_data.is_outbound, 1'b0, 1'b0, 1'b1);
                    end else begin
                      out_data_nxt = mk_out(in_data.packet_handle, in_data.packet_length,
                                            in_data.is_outbound, 1'b1, 1'b0, 1'b0);
                      dup_left_nxt = total - 6'd1;
                      state_nxt    = S_DUP;
                    end
                  end
                  default: begin
                    out_valid_nxt = 1'b1;
                    out_data_nxt  = mk_out(in_data.packet_handle, in_data.packet_length,
                                           in_data.is_outbound, 1'b0, 1'b0, 1'b1);
                  end
                endcase
              end
            end
            plf_pkg::OP_POLL: begin
              if ((cfg.hit_action == plf_pkg::ACT_LAG ||
                   cfg.miss_action == plf_pkg::ACT_LAG) && lag_count_r != '0) begin
                lag_re    = 1'b1;
                state_nxt = S_EVAL;
              end
            end
            plf_pkg::OP_FLUSH: begin
              if (lag_count_r != '0) begin
                lag_re    = 1'b1;
                state_nxt = S_EVAL;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_EVAL: begin
        if (out_free) begin
          if (due) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = mk_out(lag_rd_r[15:0], lag_rd_r[31:16], lag_rd_r[32],
                                   1'b0, 1'b1, 1'b1);
            rd_ptr_nxt    = next_ptr(rd_ptr_r);
            lag_count_nxt = lag_count_r - 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end
      S_DUP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (dup_left_r == 6'd1) begin
            out_data_nxt = mk_out(item_r.packet_handle, item_r.packet_length,
                                  item_r.is_outbound, 1'b0, 1'b0, 1'b1);
            state_nxt    = S_IDLE;
          end else begin
            out_data_nxt = mk_out(item_r.packet_handle, item_r.packet_length,
                                  item_r.is_outbound, 1'b1, 1'b0, 1'b0);
            dup_left_nxt = dup_left_r - 6'd1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold control state and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      lag_count_r <= '0;
      dup_left_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      out_data_r  <= out_data_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      lag_count_r <= lag_count_nxt;
      dup_left_r  <= dup_left_nxt;
    end
  end

  // Capture payload of the accepted transaction
  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r <= in_data;
    end
  end

  // Lag memory: write at the tail, registered read at the head
  always_ff @(posedge clk) begin
    if (lag_we) begin
      lag_mem_r[wr_ptr_r] <= {in_data.now_ms, in_data.is_outbound,
                              in_data.packet_length, in_data.packet_handle};
    end
    if (lag_re) begin
      lag_rd_r <= lag_mem_r[rd_ptr_r];
    end
  end

`ifndef SYNTHESIS
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    lag_count_r <= CNT_W'(CAP))
    else $error("lag count above capacity");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (lag_count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("empty lag queue with unequal pointers");

  a_dup_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DUP) |-> out_valid_r)
    else $error("copy run without a pending result");

  a_release_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVAL && out_free && due) |=> (lag_count_r == $past(lag_count_r) - 1'b1))
    else $error("release did not pop the lag queue");
`endif

endmodule

### tb/tb_packet_length_filter_impairment.sv
// Self-checking testbench for the packet length filter with lag, duplicate and drop actions.
module tb_packet_length_filter_impairment;

  localparam int CYCLE_LIMIT    = 1000000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int DRAIN_CYCLES   = 20;
  localparam int REPORT_LIMIT   = 10;
  localparam int LAG_CAP        = (plf_pkg::KEEP_LIMIT < plf_pkg::LAG_DEPTH_DEF) ?
                                  plf_pkg::KEEP_LIMIT : plf_pkg::LAG_DEPTH_DEF;
  localparam int ITEMS_PER_CFG  = 35;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int LAG_FILL       = 40;
  localparam int RANDOM_ITEMS   = 85;

  // Codes outside the package enums that the block must still handle
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [2:0] ACT_RSVD6 = 3'd6;
  localparam logic [2:0] ACT_RSVD7 = 3'd7;

  // Idling modes of the two channels
  localparam int IDLE_SLOW_SINK   = 0;
  localparam int IDLE_SLOW_SOURCE = 1;
  localparam int IDLE_NONE        = 2;

  typedef struct {
    logic [31:0] stamp;
    logic [15:0] handle;
    logic [15:0] length;
    logic        outbound;
  } lag_entry_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  plf_pkg::in_item_t              in_data = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  plf_pkg::out_item_t             out_data;
  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [plf_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [plf_pkg::CFG_DATA_W-1:0] pwdata = '0;
  logic [plf_pkg::CFG_DATA_W-1:0] prdata;
  logic                           pready;

  plf_pkg::cfg_t      shadow_cfg;
  lag_entry_t         lag_mirror[$];
  plf_pkg::out_item_t expected_fwd[$];
  int                 mismatch_count = 0;
  int                 cycle_count = 0;
  int                 send_gap_pct = 0;
  int                 recv_stall_pct = 0;
  int                 hold_left = 0;
  logic [31:0]        clock_ms = '0;

  packet_length_filter_impairment dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // End the run if it hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_packet_length_filter_impairment: FAIL");
      $finish;
    end
  end

  // Drive result-side stall: a long hold-off when requested, random otherwise
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic void note_error(string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) $display("ERROR: %s", msg);
  endfunction

  function automatic string show_result(plf_pkg::out_item_t r);
    return $sformatf("handle=%h length=%h outbound=%b copy=%b lag=%b last=%b",
                     r.out_handle, r.out_length, r.out_outbound, r.is_copy,
                     r.from_lag, r.last_of_run);
  endfunction

  // Check each result transaction against the oldest expected one
  always @(negedge clk) begin
    plf_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_fwd.size() == 0) begin
        note_error($sformatf("unexpected result %s", show_result(out_data)));
      end else begin
        want = expected_fwd.pop_front();
        if (out_data.out_handle !== want.out_handle ||
            out_data.out_length !== want.out_length ||
            out_data.out_outbound !== want.out_outbound ||
            out_data.is_copy !== want.is_copy ||
            out_data.from_lag !== want.from_lag ||
            out_data.last_of_run !== want.last_of_run)
          note_error($sformatf("expected %s, got %s", show_result(want),
                               show_result(out_data)));
      end
    end
  end

  function automatic void push_result(logic [15:0] handle, logic [15:0] len, logic ob,
                                      logic copy, logic lagged, logic last);
    plf_pkg::out_item_t r;
    r.out_handle   = handle;
    r.out_length   = len;
    r.out_outbound = ob;
    r.is_copy      = copy;
    r.from_lag     = lagged;
    r.last_of_run  = last;
    expected_fwd.push_back(r);
  endfunction

  function automatic void release_oldest();
    lag_entry_t e;
    e = lag_mirror.pop_front();
    push_result(e.handle, e.length, e.outbound, 1'b0, 1'b1, 1'b1);
  endfunction

  // Work out the forwarded packets for one accepted input transaction
  function automatic void predict_forwarding(plf_pkg::in_item_t it);
    logic        enabled;
    logic        matched;
    logic [2:0]  act;
    logic [5:0]  copies;
    logic [31:0] age;
    int          total;
    lag_entry_t  e;
    unique case (it.operation)
      plf_pkg::OP_POLL: begin
        if ((shadow_cfg.hit_action == plf_pkg::ACT_LAG ||
             shadow_cfg.miss_action == plf_pkg::ACT_LAG) && lag_mirror.size() > 0) begin
          age = it.now_ms - lag_mirror[0].stamp;
          if (age > shadow_cfg.lag_ms) release_oldest();
        end
      end
      plf_pkg::OP_FLUSH: begin
        if (lag_mirror.size() > 0) release_oldest();
      end
      plf_pkg::OP_PACKET: begin
        enabled = it.is_outbound ? shadow_cfg.direction_enable[1]
                                 : shadow_cfg.direction_enable[0];
        matched = (it.packet_length >= shadow_cfg.min_length) &&
                  (it.packet_length <= shadow_cfg.max_length);
        act     = matched ? shadow_cfg.hit_action : shadow_cfg.miss_action;
        copies  = matched ? shadow_cfg.matched_copies : shadow_cfg.unmatched_copies;
        // Unfiltered direction: forward as is
        if (!enabled) act = plf_pkg::ACT_PASS;
        unique case (act)
          plf_pkg::ACT_DROP, plf_pkg::ACT_RESET: ;
          plf_pkg::ACT_LAG: begin
            if (lag_mirror.size() < LAG_CAP) begin
              e.stamp    = it.now_ms;
              e.handle   = it.packet_handle;
              e.length   = it.packet_length;
              e.outbound = it.is_outbound;
              lag_mirror.push_back(e);
            end else begin
              push_result(it.packet_handle, it.packet_length, it.is_outbound,
                          1'b0, 1'b0, 1'b1);
            end
          end
          plf_pkg::ACT_DUP: begin
            total = (copies < 2) ? 1 :
                    (copies > plf_pkg::MAX_COPIES) ? plf_pkg::MAX_COPIES : copies;
            for (int k = 0; k < total - 1; k++)
              push_result(it.packet_handle, it.packet_length, it.is_outbound,
                          1'b1, 1'b0, 1'b0);
            push_result(it.packet_handle, it.packet_length, it.is_outbound,
                        1'b0, 1'b0, 1'b1);
          end
          default: begin
            push_result(it.packet_handle, it.packet_length, it.is_outbound,
                        1'b0, 1'b0, 1'b1);
          end
        endcase
      end
      default: ;
    endcase
  endfunction

  function automatic plf_pkg::in_item_t make_item(logic [1:0] op, logic [31:0] now,
                                                  logic [15:0] handle, logic [15:0] len,
                                                  logic ob);
    plf_pkg::in_item_t it;
    it.operation     = op;
    it.now_ms        = now;
    it.packet_handle = handle;
    it.packet_length = len;
    it.is_outbound   = ob;
    return it;
  endfunction

  // Offer one input transaction, hold it until accepted, then predict
  task automatic offer_descriptor(plf_pkg::in_item_t it);
    logic stalled;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    predict_forwarding(it);
  endtask

  // Stop sending and wait until every expected result has come out
  task automatic settle_idle();
    in_valid <= 1'b0;
    while (expected_fwd.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Write every register while the block is idle
  task automatic apply_config(plf_pkg::cfg_t c);
    settle_idle();
    write_reg(plf_pkg::REG_DIR_EN,   32'(c.direction_enable));
    write_reg(plf_pkg::REG_MIN_LEN,  32'(c.min_length));
    write_reg(plf_pkg::REG_MAX_LEN,  32'(c.max_length));
    write_reg(plf_pkg::REG_M_ACTION, 32'(c.hit_action));
    write_reg(plf_pkg::REG_U_ACTION, 32'(c.miss_action));
    write_reg(plf_pkg::REG_LAG_MS,   32'(c.lag_ms));
    write_reg(plf_pkg::REG_M_COPIES, 32'(c.matched_copies));
    write_reg(plf_pkg::REG_U_COPIES, 32'(c.unmatched_copies));
    shadow_cfg = c;
  endtask

  task automatic set_idling(int mode);
    unique case (mode)
      IDLE_SLOW_SINK: begin
        send_gap_pct   = 21;
        recv_stall_pct = 77;
      end
      IDLE_SLOW_SOURCE: begin
        send_gap_pct   = 77;
        recv_stall_pct = 21;
      end
      default: begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
    endcase
  endtask

  function automatic plf_pkg::cfg_t random_config();
    plf_pkg::cfg_t c;
    if ($urandom_range(99) < 70) c.direction_enable = 2'd3;
    else c.direction_enable = 2'($urandom_range(3));
    if ($urandom_range(99) < 80) c.min_length = 16'($urandom_range(1600));
    else c.min_length = 16'($urandom_range(16'hFFFF));
    if ($urandom_range(99) < 80) c.max_length = 16'(c.min_length + $urandom_range(1500));
    else c.max_length = 16'($urandom_range(16'hFFFF));
    if ($urandom_range(99) < 30) c.hit_action = plf_pkg::ACT_LAG;
    else c.hit_action = 3'($urandom_range(7));
    if ($urandom_range(99) < 25) c.miss_action = plf_pkg::ACT_DUP;
    else c.miss_action = 3'($urandom_range(7));
    if ($urandom_range(99) < 75) c.lag_ms = 14'($urandom_range(100));
    else c.lag_ms = 14'($urandom_range(14'h3FFF));
    if ($urandom_range(99) < 80) c.matched_copies = 6'($urandom_range(6));
    else c.matched_copies = 6'($urandom_range(63));
    if ($urandom_range(99) < 80) c.unmatched_copies = 6'($urandom_range(6));
    else c.unmatched_copies = 6'($urandom_range(63));
    return c;
  endfunction

  // Mostly packets, many near the window edges, with polls, flushes and unused codes as time advances
  function automatic plf_pkg::in_item_t random_descriptor();
    int          pick;
    logic [1:0]  op;
    logic [15:0] len;
    pick = $urandom_range(99);
    if (pick < 55) op = plf_pkg::OP_PACKET;
    else if (pick < 80) op = plf_pkg::OP_POLL;
    else if (pick < 95) op = plf_pkg::OP_FLUSH;
    else op = OP_UNUSED;
    pick = $urandom_range(99);
    if (pick < 10) len = shadow_cfg.min_length - 16'd1;
    else if (pick < 20) len = shadow_cfg.min_length;
    else if (pick < 30) len = shadow_cfg.max_length;
    else if (pick < 40) len = shadow_cfg.max_length + 16'd1;
    else if (pick < 70) len = 16'($urandom_range(2000));
    else len = 16'($urandom_range(16'hFFFF));
    if ($urandom_range(99) < 4) clock_ms = $urandom();
    else clock_ms = clock_ms + $urandom_range(shadow_cfg.lag_ms / 3 + 2);
    return make_item(op, clock_ms, 16'($urandom_range(16'hFFFF)), len,
                     1'($urandom_range(1)));
  endfunction

  // Reset values: matched lengths dropped, the rest forwarded, nothing lagged
  task automatic test_reset_defaults();
    offer_descriptor(make_item(plf_pkg::OP_PACKET, 32'd0, 16'h0000,
                               plf_pkg::DEFAULT_MIN_LEN - 16'd1, 1'b0));
    offer_descriptor(make_item(plf_pkg::OP_PACKET, 32'd1, 16'h0001,
                               plf_pkg::DEFAULT_MIN_LEN, 1'b0));
    offer_descriptor(make_item(plf_pkg::OP_PACKET, 32'd2, 16'h8000,
                               plf_pkg::DEFAULT_MAX_LEN, 1'b1));
    offer_descriptor(make_item(plf_pkg::OP_PACKET, 32'd3, 16'h7FFF,
                               plf_pkg::DEFAULT_MAX_LEN + 16'd1, 1'b1));
    offer_descriptor(make_item(plf_pkg::OP_PACKET, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b0));
    offer_descriptor(make_item(plf_pkg::OP_PACKET, 32'h5555_AAAA, 16'h5A5A, 16'h0000, 1'b1));
    offer_descriptor(make_item(plf_pkg::OP_POLL, 32'hFFFF_FFFF, 16'h0000, 16'h0000, 1'b0));
    offer_descriptor(make_item(plf_pkg::OP_FLUSH, 32'd0, 16'h0000, 16'h0000, 1'b0));
    offer_descriptor(make_item(OP_UNUSED, 32'hAAAA_5555, 16'hFFFF, 16'hFFFF, 1'b1));
  endtask

  // Every action code on both classes, direction enables, copy counts, empty window
  task automatic test_actions();
    plf_pkg::cfg_t c;
    logic [5:0]    copy_set[5];
    copy_set = '{6'd0, 6'd1, 6'd50, 6'd51, 6'd63};
    c = shadow_cfg;
    c.min_length       = 16'd100;
    c.max_length       = 16'd200;
    c.matched_copies   = 6'd3;
    c.unmatched_copies = 6'd4;
    for (int a = 0; a < 8; a++) begin
      c.hit_action  = 3'(a);
      c.miss_action = 3'(7 - a);
      apply_config(c);
      offer_descriptor(make_item(plf_pkg::OP_PACKET, 32'd10, 16'($urandom_range(16'hFFFF)),
                                 16'd150, 1'($urandom_range(1))));
      offer_descriptor(make_item(plf_pkg::OP_PACKET, 32'd11, 16'($urandom_range(16'hFFFF)),
                                 16'd201, 1'($urandom_range(1))));
    end
    offer_descriptor(make_item(plf_pkg::OP_FLUSH, 32'd12, 16'h0000, 16'h0000, 1'b0));
    offer_descriptor(make_item(plf_pkg::OP_FLUSH, 32'd13, 16'h0000, 16'h0000, 1'b0));
    offer_descriptor(make_item(plf_pkg::OP_FLUSH, 32'd14, 16'h0000, 16'h0000, 1'b0));

    // Direction enables: duplicate where filtered, forward where not
    c.hit_action = plf_pkg::ACT_DUP;
    for (int d = 0; d < 4; d++) begin
      c.direction_enable = 2'(d);
      apply_config(c);
      offer_descriptor(make_item(plf_pkg::OP_PACKET, 32'd20, 16'h1234, 16'd150, 1'b0));
      offer_descriptor(make_item(plf_pkg::OP_PACKET, 32'd21, 16'h4321, 16'd150, 1'b1));
    end

    // Copy counts below two and above the cap
    foreach (copy_set[i]) begin
      c.matched_copies = copy_set[i];
      apply_config(c);
      offer_descriptor(make_item(plf_pkg::OP_PACKET, 32'd30, 16'hC0DE, 16'd100, 1'b1));
    end

    // Empty window: min above max matches nothing
    c.min_length  = 16'd1000;
    c.max_length  = 16'd999;
    c.hit_action  = plf_pkg::ACT_PASS;
    c.miss_action = plf_pkg::ACT_DROP;
    apply_config(c);
    offer_descriptor(make_item(plf_pkg::OP_PACKET, 32'd40, 16'hBEEF, 16'd999, 1'b0));
    offer_descriptor(make_item(plf_pkg::OP_PACKET, 32'd41, 16'hBEEF, 16'd1000, 1'b0));
    c.miss_action = ACT_RSVD6;
    apply_config(c);
    offer_descriptor(make_item(plf_pkg::OP_PACKET, 32'd42, 16'hF00D, 16'd1000, 1'b1));
  endtask

  // Due boundary, time wrap, extreme lag delays, poll without a lag action
  task automatic test_lag_timing();
    plf_pkg::cfg_t c;
    c = shadow_cfg;
    c.direction_enable = 2'd3;
    c.min_length       = 16'h0000;
    c.max_length       = 16'hFFFF;
    c.hit_action       = plf_pkg::ACT_LAG;
    c.miss_action      = ACT_RSVD7;
    c.lag_ms           = 14'd0;
    apply_config(c);
    offer_descriptor(make_item(plf_pkg::OP_PACKET, 32'hFFFF_FFFF, 16'hA001, 16'd64, 1'b0));
    offer_descriptor(make_item(plf_pkg::OP_POLL, 32'hFFFF_FFFF, 16'h0000, 16'h0000, 1'b0));
    offer_descriptor(make_item(plf_pkg::OP_POLL, 32'h0000_0000, 16'h0000, 16'h0000, 1'b0));

    c.lag_ms = 14'h3FFF;
    apply_config(c);
    offer_descriptor(make_item(plf_pkg::OP_PACKET, 32'd100, 16'hA002, 16'hFFFF, 1'b1));
    offer_descriptor(make_item(plf_pkg::OP_POLL, 32'd100 + 32'h3FFF, 16'h0000, 16'h0000,
                               1'b0));
    offer_descriptor(make_item(plf_pkg::OP_POLL, 32'd100 + 32'h4000, 16'h0000, 16'h0000,
                               1'b0));

    // Entry left behind, then lag removed from both actions
    offer_descriptor(make_item(plf_pkg::OP_PACKET, 32'd5, 16'hA003, 16'd0, 1'b0));
    c.hit_action = plf_pkg::ACT_PASS;
    apply_config(c);
    offer_descriptor(make_item(plf_pkg::OP_POLL, 32'h8000_0000, 16'h0000, 16'h0000, 1'b0));
    offer_descriptor(make_item(plf_pkg::OP_FLUSH, 32'h8000_0001, 16'h0000, 16'h0000, 1'b0));
    offer_descriptor(make_item(plf_pkg::OP_FLUSH, 32'h8000_0002, 16'h0000, 16'h0000, 1'b0));
  endtask

  // Long receiver hold-off while duplicate runs keep coming, then a full pause
  task automatic test_backpressure();
    plf_pkg::cfg_t c;
    c = shadow_cfg;
    c.direction_enable = 2'd3;
    c.min_length       = 16'd0;
    c.max_length       = 16'd1000;
    c.hit_action       = plf_pkg::ACT_DUP;
    c.miss_action      = plf_pkg::ACT_PASS;
    c.matched_copies   = 6'd6;
    apply_config(c);
    hold_left = HOLD_OFF_CYCLES;
    for (int i = 0; i < 20; i++)
      offer_descriptor(make_item(plf_pkg::OP_PACKET, clock_ms, 16'($urandom_range(16'hFFFF)),
                                 16'($urandom_range(2000)), 1'($urandom_range(1))));
    settle_idle();
    for (int i = 0; i < 5; i++)
      offer_descriptor(make_item(plf_pkg::OP_PACKET, clock_ms, 16'($urandom_range(16'hFFFF)),
                                 16'($urandom_range(2000)), 1'($urandom_range(1))));
  endtask

  // Fill part of the lag queue, test the due boundary, then drain by polls and flushes
  task automatic test_lag_drain();
    plf_pkg::cfg_t c;
    int            n;
    c = shadow_cfg;
    c.direction_enable = 2'd3;
    c.hit_action       = plf_pkg::ACT_LAG;
    c.miss_action      = plf_pkg::ACT_LAG;
    c.lag_ms           = 14'h3FFF;
    apply_config(c);
    clock_ms = $urandom();
    for (int i = 0; i < LAG_FILL; i++)
      offer_descriptor(make_item(plf_pkg::OP_PACKET, clock_ms, 16'($urandom_range(16'hFFFF)),
                                 16'($urandom_range(16'hFFFF)), 1'($urandom_range(1))));
    offer_descriptor(make_item(plf_pkg::OP_POLL, clock_ms + 32'h3FFF, 16'h0000, 16'h0000,
                               1'b0));
    offer_descriptor(make_item(plf_pkg::OP_POLL, clock_ms + 32'h4000, 16'h0000, 16'h0000,
                               1'b0));
    n = 0;
    while (lag_mirror.size() > 0) begin
      if (n % 2 == 0)
        offer_descriptor(make_item(plf_pkg::OP_POLL, clock_ms + 32'd20000, 16'h0000,
                                   16'h0000, 1'b0));
      else
        offer_descriptor(make_item(plf_pkg::OP_FLUSH, clock_ms, 16'h0000, 16'h0000, 1'b0));
      n++;
    end
  endtask

  task automatic test_random(int mode, int n_items);
    set_idling(mode);
    clock_ms = 32'hFFFF_FFFF - $urandom_range(4000);
    for (int i = 0; i < n_items; i++) begin
      if (i % ITEMS_PER_CFG == 0) apply_config(random_config());
      offer_descriptor(random_descriptor());
    end
  endtask

  initial begin
    shadow_cfg.direction_enable = 2'd3;
    shadow_cfg.min_length       = plf_pkg::DEFAULT_MIN_LEN;
    shadow_cfg.max_length       = plf_pkg::DEFAULT_MAX_LEN;
    shadow_cfg.hit_action       = plf_pkg::ACT_DROP;
    shadow_cfg.miss_action      = plf_pkg::ACT_PASS;
    shadow_cfg.lag_ms           = 14'd50;
    shadow_cfg.matched_copies   = 6'd2;
    shadow_cfg.unmatched_copies = 6'd2;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_idling(IDLE_SLOW_SINK);
    test_reset_defaults();
    test_actions();
    test_lag_timing();
    test_backpressure();
    test_lag_drain();
    test_random(IDLE_SLOW_SINK, RANDOM_ITEMS);
    test_random(IDLE_SLOW_SOURCE, RANDOM_ITEMS);
    test_random(IDLE_NONE, RANDOM_ITEMS);

    // Drain, then give late or extra results time to show up
    settle_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_fwd.size() != 0)
      note_error($sformatf("%0d expected results never arrived", expected_fwd.size()));
    if (mismatch_count == 0)
      $display("tb_packet_length_filter_impairment: PASS");
    else
      $display("tb_packet_length_filter_impairment: FAIL");
    $finish;
  end

endmodule
